@@ hw/rtl/lttc_pkg.sv @@
// Package with constants, types and tables for the lidar time-to-collision brake.
package lttc_pkg;

    localparam int MAX_BEAMS_DEF    = 1024;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int ANG_W   = 19;
    localparam int CORD_W  = 34;
    localparam int ATAN_N  = 24;
    localparam int DIV_W   = 16;
    localparam int DIV_CW  = 4;
    localparam int RK_W    = 26;
    localparam int DEN_W   = 30;

    localparam logic [ANG_W-1:0] TWO_PI_U  = 19'd411775;
    localparam logic [ANG_W-1:0] PI_U      = 19'd205887;
    localparam logic [ANG_W-1:0] HALF_PI_U = 19'd102944;
    localparam logic signed [CORD_W-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic [15:0] NO_TTC = 16'hFFFF;

    localparam logic [2:0] REG_FORWARD_SPEED = 3'd0;
    localparam logic [2:0] REG_BRAKE_TIME    = 3'd1;
    localparam logic [2:0] REG_REVERSE_SPEED = 3'd2;
    localparam logic [2:0] REG_START_ANGLE   = 3'd3;
    localparam logic [2:0] REG_ANGLE_STEP    = 3'd4;

    localparam logic [14:0] FORWARD_SPEED_RST = 15'd500;
    localparam logic [15:0] BRAKE_TIME_RST    = 16'd1000;
    localparam logic [14:0] REVERSE_SPEED_RST = 15'd2000;
    localparam logic [18:0] START_ANGLE_RST   = 19'h4DBC0;
    localparam logic [15:0] ANGLE_STEP_RST    = 16'd384;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_CORDIC,
        ST_ROUND,
        ST_MUL,
        ST_DIVCHK,
        ST_DIV,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    function automatic logic signed [CORD_W-1:0] atan_q30(input logic [4:0] idx);
        logic signed [CORD_W-1:0] v;
        case (idx)
            5'd0:    v = 34'sd843314856;
            5'd1:    v = 34'sd497837829;
            5'd2:    v = 34'sd263043836;
            5'd3:    v = 34'sd133525158;
            5'd4:    v = 34'sd67021686;
            5'd5:    v = 34'sd33543515;
            5'd6:    v = 34'sd16775850;
            5'd7:    v = 34'sd8388437;
            5'd8:    v = 34'sd4194282;
            5'd9:    v = 34'sd2097149;
            5'd10:   v = 34'sd1048575;
            5'd11:   v = 34'sd524287;
            5'd12:   v = 34'sd262143;
            5'd13:   v = 34'sd131071;
            5'd14:   v = 34'sd65535;
            5'd15:   v = 34'sd32767;
            5'd16:   v = 34'sd16383;
            5'd17:   v = 34'sd8191;
            5'd18:   v = 34'sd4095;
            5'd19:   v = 34'sd2047;
            5'd20:   v = 34'sd1023;
            5'd21:   v = 34'sd511;
            5'd22:   v = 34'sd255;
            5'd23:   v = 34'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/lidar_ttc_emergency_brake.sv @@
// Top level of the lidar time-to-collision emergency brake.
// Each input beat carries one beam range and a flag that marks the last beam of a scan.
// The beam angle starts at start_angle on the first beam and advances by angle_step.
// A shared CORDIC stage iterates CORDIC_STEPS times to get the beam cosine, then a
// restoring divider of 16 steps forms the time to collision in ms.
// A beam inside the forward window runs through the CORDIC and the divider before the next
// beat can be taken; the divider is skipped when its closing speed is not positive or its
// time to collision saturates. Any other beam skips both, and a last beam adds a result
// step. The block takes no new beam until it is through with the current one.
// Only the last beam of a scan produces a result beat, with the speed command, brake,
// reversing flag and the minimum time to collision of the scan.
// The result sits in an output register; the block takes further beams while it waits.
// If the receiver stalls and a second result is due, the block holds in its final step.
// Reset is synchronous and active low; it restores the register defaults, clears the
// beam count and the reversing mode, and drops the result valid flag.
// Configuration writes take effect at once and must be made while the block is idle.
module lidar_ttc_emergency_brake
    import lttc_pkg::*;
#(
    parameter int MAX_BEAMS    = MAX_BEAMS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [18:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [15:0]        s_range_mm,
    input  logic               s_last_beam,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_drive_speed,
    output logic               m_brake_active,
    output logic               m_is_reversing,
    output logic [15:0]        m_min_ttc_ms
);

    localparam int CW = $clog2(MAX_BEAMS + 1);
    localparam int IW = $clog2(CORDIC_STEPS);

    state_t state_reg, state_next;

    logic [14:0]       fwd_speed_reg;
    logic [15:0]       brake_time_reg;
    logic [14:0]       rev_speed_reg;
    logic signed [18:0] start_angle_reg;
    logic [15:0]       angle_step_reg;

    logic [ANG_W-1:0]  angle_reg;
    logic [15:0]       min_ttc_reg;
    logic              rev_mode_reg;
    logic [CW-1:0]     beam_count_reg;

    logic [15:0]       range_reg;
    logic              last_reg;
    logic              live_reg;
    logic              hit_reg;
    logic [RK_W-1:0]   rk_reg;
    logic signed [CORD_W-1:0] x_reg, y_reg, z_reg;
    logic [IW-1:0]     iter_reg;
    logic signed [15:0] cos_reg;
    logic [DEN_W-1:0]  denom_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  q_reg;
    logic [DIV_CW-1:0] div_cnt_reg;

    logic              m_valid_reg;
    logic signed [15:0] m_speed_reg;
    logic              m_brake_reg;
    logic              m_rev_reg;
    logic [15:0]       m_min_reg;

    logic              accept;
    logic              out_free;
    logic [ANG_W-1:0]  start_wrapped;
    logic signed [ANG_W:0] a_signed;
    logic              in_window;
    logic signed [CORD_W-1:0] dx, dy, atan_v, x_rnd;
    logic [ANG_W:0]    ang_sum;
    logic [DEN_W:0]    trial;
    logic              trial_ge;
    logic              div_ovf;
    logic              brake_d, rev_d;
    logic signed [15:0] speed_d;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign start_wrapped = start_angle_reg[18]
        ? ANG_W'($signed({1'b0, TWO_PI_U}) + {start_angle_reg[18], start_angle_reg})
        : start_angle_reg;
    assign a_signed  = (angle_reg > PI_U) ? ($signed({1'b0, angle_reg}) - $signed({1'b0, TWO_PI_U}))
                                          : $signed({1'b0, angle_reg});
    assign in_window = (a_signed > -$signed({1'b0, HALF_PI_U}))
                    && (a_signed < $signed({1'b0, HALF_PI_U}));

    assign dx     = y_reg >>> iter_reg;
    assign dy     = x_reg >>> iter_reg;
    assign atan_v = atan_q30(5'(iter_reg));
    assign x_rnd  = (x_reg + 34'sd16384) >>> 15;

    assign ang_sum  = {1'b0, angle_reg} + {4'd0, angle_step_reg};
    assign trial    = {rem_reg, q_reg[DIV_W-1]};
    assign trial_ge = trial >= {1'b0, denom_reg};
    assign div_ovf  = {5'd0, rk_reg[RK_W-1:1]} >= denom_reg;

    always_comb begin
        brake_d = min_ttc_reg < brake_time_reg;
        speed_d = brake_d ? 16'sd0 : $signed({1'b0, fwd_speed_reg});
        rev_d   = rev_mode_reg;
        if (rev_mode_reg) begin
            if (min_ttc_reg > brake_time_reg) begin
                rev_d   = 1'b0;
                speed_d = 16'sd0;
                brake_d = 1'b0;
            end else begin
                speed_d = -$signed({1'b0, rev_speed_reg});
            end
        end else if (brake_d) begin
            rev_d   = 1'b1;
            speed_d = -$signed({1'b0, rev_speed_reg});
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_PREP;
            ST_PREP:   state_next = (live_reg && in_window) ? ST_CORDIC : ST_UPDATE;
            ST_CORDIC: if (iter_reg == IW'(CORDIC_STEPS - 1)) state_next = ST_ROUND;
            ST_ROUND:  state_next = ST_MUL;
            ST_MUL:    state_next = ST_DIVCHK;
            ST_DIVCHK: state_next = (hit_reg && !div_ovf) ? ST_DIV : ST_UPDATE;
            ST_DIV:    if (div_cnt_reg == DIV_CW'(DIV_W - 1)) state_next = ST_UPDATE;
            ST_UPDATE: state_next = last_reg ? ST_FINISH : ST_IDLE;
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready        = state_reg == ST_IDLE;
        m_valid        = m_valid_reg;
        m_drive_speed  = m_speed_reg;
        m_brake_active = m_brake_reg;
        m_is_reversing = m_rev_reg;
        m_min_ttc_ms   = m_min_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            fwd_speed_reg   <= FORWARD_SPEED_RST;
            brake_time_reg  <= BRAKE_TIME_RST;
            rev_speed_reg   <= REVERSE_SPEED_RST;
            start_angle_reg <= START_ANGLE_RST;
            angle_step_reg  <= ANGLE_STEP_RST;
            rev_mode_reg    <= 1'b0;
            beam_count_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_FORWARD_SPEED: fwd_speed_reg   <= cfg_wdata[14:0];
                    REG_BRAKE_TIME:    brake_time_reg  <= cfg_wdata[15:0];
                    REG_REVERSE_SPEED: rev_speed_reg   <= cfg_wdata[14:0];
                    REG_START_ANGLE:   start_angle_reg <= cfg_wdata;
                    REG_ANGLE_STEP:    angle_step_reg  <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_UPDATE && live_reg) begin
                beam_count_reg <= beam_count_reg + CW'(1);
            end
            if (state_reg == ST_FINISH && out_free) begin
                m_valid_reg    <= 1'b1;
                rev_mode_reg   <= rev_d;
                beam_count_reg <= '0;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    range_reg <= s_range_mm;
                    last_reg  <= s_last_beam;
                    live_reg  <= beam_count_reg < CW'(MAX_BEAMS);
                    if (beam_count_reg == '0) begin
                        angle_reg   <= start_wrapped;
                        min_ttc_reg <= NO_TTC;
                    end
                end
            end
            ST_PREP: begin
                rk_reg   <= RK_W'(range_reg) * RK_W'(1000);
                x_reg    <= GAIN_Q30;
                y_reg    <= '0;
                z_reg    <= CORD_W'(a_signed) <<< 14;
                iter_reg <= '0;
                hit_reg  <= 1'b0;
            end
            ST_CORDIC: begin
                if (!z_reg[CORD_W-1]) begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - atan_v;
                end else begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + atan_v;
                end
                iter_reg <= iter_reg + IW'(1);
            end
            ST_ROUND: begin
                if (x_rnd > 34'sd32767) begin
                    cos_reg <= 16'sd32767;
                end else if (x_rnd < -34'sd32768) begin
                    cos_reg <= -16'sd32768;
                end else begin
                    cos_reg <= x_rnd[15:0];
                end
            end
            ST_MUL: begin
                denom_reg <= DEN_W'(fwd_speed_reg) * DEN_W'(cos_reg[14:0]);
                hit_reg   <= (cos_reg > 16'sd0) && (fwd_speed_reg != '0);
            end
            ST_DIVCHK: begin
                rem_reg     <= {5'd0, rk_reg[RK_W-1:1]};
                q_reg       <= {rk_reg[0], 15'd0};
                div_cnt_reg <= '0;
                hit_reg     <= hit_reg && !div_ovf;
            end
            ST_DIV: begin
                rem_reg     <= trial_ge ? DEN_W'(trial - {1'b0, denom_reg}) : DEN_W'(trial);
                q_reg       <= {q_reg[DIV_W-2:0], trial_ge};
                div_cnt_reg <= div_cnt_reg + DIV_CW'(1);
            end
            ST_UPDATE: begin
                if (live_reg) begin
                    angle_reg <= (ang_sum >= {1'b0, TWO_PI_U})
                        ? ANG_W'(ang_sum - {1'b0, TWO_PI_U}) : ANG_W'(ang_sum);
                    if (hit_reg && q_reg < min_ttc_reg) begin
                        min_ttc_reg <= q_reg;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_speed_reg <= speed_d;
                    m_brake_reg <= brake_d;
                    m_rev_reg   <= rev_d;
                    m_min_reg   <= min_ttc_reg;
                end
            end
            default: ;
        endcase
    end

    a_rev_not_forward: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_reversing |-> m_drive_speed <= 16'sd0)
        else $error("reversing result with a forward speed");

    a_brake_implies_rev: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_brake_active |-> m_is_reversing)
        else $error("brake result without reversing mode");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        beam_count_reg <= CW'(MAX_BEAMS))
        else $error("beam count beyond its limit");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready held after a beat was taken");

endmodule

@@ tb/lidar_ttc_emergency_brake_tb.sv @@
// Self-checking testbench for the lidar time-to-collision emergency brake.
`timescale 1ns / 100ps

module lidar_ttc_emergency_brake_tb;
    import lttc_pkg::*;

    typedef struct packed {
        logic [15:0] range_mm;
        logic        last_beam;
    } beam_t;

    typedef struct packed {
        logic signed [15:0] drive_speed;
        logic               brake_active;
        logic               is_reversing;
        logic [15:0]        min_ttc_ms;
    } brake_cmd_t;

    localparam int     SCAN_BEAM_LIMIT = 1024;
    localparam int     CORDIC_ITERS    = 16;
    localparam longint CORDIC_GAIN     = 652032874;
    localparam longint ANG_PI          = 205887;
    localparam longint ANG_HALF_PI     = 102944;
    localparam longint ANG_TWO_PI      = 411775;
    localparam int     NO_HIT_MS       = 65535;
    localparam int     IDLE_CYCLES     = 64;

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               cfg_wr_en      = 1'b0;
    logic [2:0]         cfg_index      = REG_FORWARD_SPEED;
    logic [18:0]        cfg_wdata      = '0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [15:0]        s_range_mm     = '0;
    logic               s_last_beam    = 1'b0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic signed [15:0] m_drive_speed;
    logic               m_brake_active;
    logic               m_is_reversing;
    logic [15:0]        m_min_ttc_ms;

    beam_t      beam_q[$];
    brake_cmd_t cmd_q[$];
    int         beams_outstanding = 0;
    int         mismatches        = 0;
    bit         steady_flow       = 1'b0;
    int         pause_left        = 0;
    int         stall_left        = 0;

    longint arctan_q30 [16] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767
    };

    int     fwd_speed  = 500;
    int     brake_ms   = 1000;
    int     rev_speed  = 2000;
    int     start_ang  = -205888;
    int     step_ang   = 384;
    longint beam_ang   = 0;
    int     scan_min   = NO_HIT_MS;
    bit     reversing  = 1'b0;
    int     scan_beams = 0;

    lidar_ttc_emergency_brake dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_range_mm     (s_range_mm),
        .s_last_beam    (s_last_beam),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_drive_speed  (m_drive_speed),
        .m_brake_active (m_brake_active),
        .m_is_reversing (m_is_reversing),
        .m_min_ttc_ms   (m_min_ttc_ms)
    );

    always #5 aclk = ~aclk;

    function automatic longint reduce_angle(input longint a);
        longint r;
        r = a % ANG_TWO_PI;
        if (r < 0) begin
            r += ANG_TWO_PI;
        end
        return r;
    endfunction

    function automatic int cordic_cos(input longint ang);
        longint x, y, z, dx, dy;
        x = CORDIC_GAIN;
        y = 0;
        z = ang * 16384;
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= arctan_q30[i];
            end else begin
                x += dx;
                y -= dy;
                z += arctan_q30[i];
            end
        end
        x = (x + 16384) >>> 15;
        if (x > 32767) begin
            x = 32767;
        end
        if (x < -32768) begin
            x = -32768;
        end
        return int'(x);
    endfunction

    // Updates the scan state for one beam and queues the command due on a last beam.
    function automatic void advance_scan(input logic [15:0] range_mm, input logic last);
        longint     a, rng, ttc;
        int         cosv, speed;
        bit         brake;
        brake_cmd_t cmd;
        if (scan_beams == 0) begin
            beam_ang = reduce_angle(start_ang);
            scan_min = NO_HIT_MS;
        end
        if (scan_beams < SCAN_BEAM_LIMIT) begin
            a = beam_ang;
            if (a > ANG_PI) begin
                a -= ANG_TWO_PI;
            end
            if (a > -ANG_HALF_PI && a < ANG_HALF_PI) begin
                cosv = cordic_cos(a);
                if (cosv > 0 && fwd_speed != 0) begin
                    rng = range_mm;
                    ttc = (rng * 32768000) / (longint'(fwd_speed) * cosv);
                    if (ttc > NO_HIT_MS) begin
                        ttc = NO_HIT_MS;
                    end
                    if (ttc < scan_min) begin
                        scan_min = int'(ttc);
                    end
                end
            end
            scan_beams++;
            beam_ang = reduce_angle(beam_ang + step_ang);
        end
        if (last) begin
            brake = scan_min < brake_ms;
            speed = brake ? 0 : fwd_speed;
            if (reversing) begin
                if (scan_min > brake_ms) begin
                    reversing = 1'b0;
                    speed = 0;
                    brake = 1'b0;
                end else begin
                    speed = -rev_speed;
                end
            end else if (brake) begin
                reversing = 1'b1;
                speed = -rev_speed;
            end
            cmd.drive_speed  = speed[15:0];
            cmd.brake_active = brake;
            cmd.is_reversing = reversing;
            cmd.min_ttc_ms   = scan_min[15:0];
            cmd_q.push_back(cmd);
            scan_beams = 0;
        end
    endfunction

    function automatic int pick_pause();
        int r;
        r = $urandom_range(99, 0);
        if (steady_flow || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 5);
    endfunction

    function automatic logic [15:0] pick_range();
        int r;
        r = $urandom_range(9, 0);
        if (r == 0) begin
            return 16'd0;
        end
        if (r == 1) begin
            return 16'hFFFF;
        end
        if (r < 5) begin
            return 16'($urandom_range(3000, 0));
        end
        return 16'($urandom_range(65535, 0));
    endfunction

    task automatic add_beam(input logic [15:0] range_mm, input logic last);
        beam_t b;
        b.range_mm  = range_mm;
        b.last_beam = last;
        beam_q.push_back(b);
        beams_outstanding++;
    endtask

    // Waits until every beam is taken and every command has arrived, then lets
    // the block finish any beam that produces no result beat.
    task automatic settle();
        while (beams_outstanding != 0 || cmd_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (IDLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [18:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_FORWARD_SPEED: fwd_speed = int'(val[14:0]);
            REG_BRAKE_TIME:    brake_ms  = int'(val[15:0]);
            REG_REVERSE_SPEED: rev_speed = int'(val[14:0]);
            REG_START_ANGLE:   start_ang = {{13{val[18]}}, val};
            REG_ANGLE_STEP:    step_ang  = int'(val[15:0]);
            default: ;
        endcase
    endtask

    task automatic shuffle_config();
        bit wide;
        int pick;
        wide = ($urandom_range(7, 0) == 0);
        pick = $urandom_range(9, 0);
        write_reg(REG_FORWARD_SPEED, 19'(wide ? $urandom_range(32767, 0) :
                  pick == 0 ? 0 : pick == 1 ? 20000 : $urandom_range(20000, 1)));
        pick = $urandom_range(9, 0);
        write_reg(REG_BRAKE_TIME, 19'(wide ? $urandom_range(65535, 0) :
                  pick == 0 ? 0 : pick == 1 ? 65534 : $urandom_range(8000, 0)));
        pick = $urandom_range(9, 0);
        write_reg(REG_REVERSE_SPEED, 19'(wide ? $urandom_range(32767, 0) :
                  pick == 0 ? 0 : pick == 1 ? 20000 : $urandom_range(20000, 1)));
        pick = $urandom_range(9, 0);
        write_reg(REG_START_ANGLE, 19'(wide ? $urandom_range(524287, 0) :
                  pick == 0 ? -205888 : pick == 1 ? 205888 :
                  $urandom_range(411776, 0) - 205888));
        pick = $urandom_range(9, 0);
        write_reg(REG_ANGLE_STEP, 19'(pick == 0 ? 0 : pick == 1 ? 65535 :
                  pick < 6 ? $urandom_range(2000, 0) : $urandom_range(65535, 0)));
    endtask

    always @(posedge aclk) begin
        beam_t nb;
        if (!aresetn) begin
            s_valid    <= 1'b0;
            pause_left <= 0;
        end else if (!s_valid || s_ready) begin
            if (pause_left != 0) begin
                s_valid    <= 1'b0;
                pause_left <= pause_left - 1;
            end else if (beam_q.size() != 0) begin
                nb = beam_q.pop_front();
                s_valid     <= 1'b1;
                s_range_mm  <= nb.range_mm;
                s_last_beam <= nb.last_beam;
                pause_left  <= pick_pause();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!steady_flow && $urandom_range(7, 0) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= pick_pause();
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        brake_cmd_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                beams_outstanding--;
                advance_scan(s_range_mm, s_last_beam);
            end
            if (m_valid && m_ready) begin
                if (cmd_q.size() == 0) begin
                    $error("result beat with no command expected");
                    mismatches++;
                end else begin
                    want = cmd_q.pop_front();
                    if (m_drive_speed !== want.drive_speed) begin
                        $error("drive_speed expected %0d got %0d",
                               want.drive_speed, m_drive_speed);
                        mismatches++;
                    end
                    if (m_brake_active !== want.brake_active) begin
                        $error("brake_active expected %0b got %0b",
                               want.brake_active, m_brake_active);
                        mismatches++;
                    end
                    if (m_is_reversing !== want.is_reversing) begin
                        $error("is_reversing expected %0b got %0b",
                               want.is_reversing, m_is_reversing);
                        mismatches++;
                    end
                    if (m_min_ttc_ms !== want.min_ttc_ms) begin
                        $error("min_ttc_ms expected %0d got %0d",
                               want.min_ttc_ms, m_min_ttc_ms);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        #(10_000_000);
        $display("[lidar_ttc_emergency_brake] ERROR");
        $finish;
    end

    initial begin
        int count, len, k;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Register defaults: the first beams point backward and are skipped.
        add_beam(16'd0, 1'b0);
        add_beam(16'hFFFF, 1'b0);
        add_beam(16'd1234, 1'b1);
        add_beam(16'd0, 1'b1);
        settle();

        // Straight ahead at a forward speed of 20000: walk through entering and leaving reverse.
        write_reg(REG_FORWARD_SPEED, 19'd20000);
        write_reg(REG_BRAKE_TIME, 19'd1000);
        write_reg(REG_REVERSE_SPEED, 19'd20000);
        write_reg(REG_START_ANGLE, 19'd0);
        write_reg(REG_ANGLE_STEP, 19'd0);
        add_beam(16'd0, 1'b1);
        add_beam(16'hFFFF, 1'b1);
        add_beam(16'hFFFF, 1'b1);
        add_beam(16'd100, 1'b0);
        add_beam(16'hFFFF, 1'b1);
        settle();

        // The minimum equals the threshold while reversing.
        write_reg(REG_BRAKE_TIME, 19'd0);
        add_beam(16'd0, 1'b1);
        settle();

        // Zero forward speed skips every beam.
        write_reg(REG_BRAKE_TIME, 19'd65534);
        write_reg(REG_FORWARD_SPEED, 19'd0);
        write_reg(REG_REVERSE_SPEED, 19'd0);
        add_beam(16'd0, 1'b0);
        add_beam(16'd5, 1'b1);
        settle();

        // Start angle rewritten in the middle of a scan.
        write_reg(REG_FORWARD_SPEED, 19'd1);
        write_reg(REG_START_ANGLE, 19'd205888);
        write_reg(REG_ANGLE_STEP, 19'd65535);
        add_beam(16'd7, 1'b0);
        add_beam(16'd7, 1'b0);
        settle();
        write_reg(REG_START_ANGLE, -19'sd102944);
        write_reg(REG_ANGLE_STEP, 19'd1);
        add_beam(16'hFFFF, 1'b1);
        add_beam(16'd9, 1'b0);
        add_beam(16'd9, 1'b1);
        settle();

        // Beams right at the edge of the forward half plane.
        write_reg(REG_FORWARD_SPEED, 19'd300);
        write_reg(REG_BRAKE_TIME, 19'd5000);
        write_reg(REG_START_ANGLE, 19'd102943);
        add_beam(16'd50, 1'b0);
        add_beam(16'd50, 1'b0);
        add_beam(16'd50, 1'b1);
        settle();

        // Scan longer than the beam limit; the late close beams must be ignored.
        write_reg(REG_FORWARD_SPEED, 19'd3000);
        write_reg(REG_BRAKE_TIME, 19'd2000);
        write_reg(REG_REVERSE_SPEED, 19'd1500);
        write_reg(REG_START_ANGLE, -19'sd25000);
        write_reg(REG_ANGLE_STEP, 19'd50);
        steady_flow = 1'($urandom_range(1, 0));
        for (k = 0; k < 1030; k++) begin
            add_beam(k < SCAN_BEAM_LIMIT ? 16'($urandom_range(65535, 20000)) : 16'd0,
                     k == 1029);
        end
        settle();

        for (int ph = 0; ph < 11; ph++) begin
            shuffle_config();
            steady_flow = (ph % 4 == 3);
            count = 0;
            while (count < 70) begin
                len = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 20) :
                      $urandom_range(12, 1);
                for (k = 0; k < len; k++) begin
                    add_beam(pick_range(), k == len - 1);
                end
                count += len;
            end
            // Sometimes leave a scan open across the next register update.
            if ($urandom_range(2, 0) == 0) begin
                len = $urandom_range(5, 1);
                for (k = 0; k < len; k++) begin
                    add_beam(pick_range(), 1'b0);
                end
            end
            settle();
        end

        steady_flow = 1'b0;
        add_beam(pick_range(), 1'b1);
        settle();
        if (mismatches == 0) begin
            $display("[lidar_ttc_emergency_brake] OK");
        end else begin
            $display("[lidar_ttc_emergency_brake] ERROR");
        end
        $finish;
    end

endmodule
